[hw/rtl/xmsd_pkg.sv]
// shared types and constants for the masked string decoder
`timescale 1ns / 1ps

package xmsd_pkg;

    localparam int LENGTH_BITS = 32;

    localparam logic [7:0]  PREFIX_EMPTY   = 8'h00;
    localparam logic [7:0]  PREFIX_WIDE_X  = 8'h7F;
    localparam logic [7:0]  PREFIX_NARR_X  = 8'h80;
    localparam logic [15:0] MASK_WIDE      = 16'hAAAA;
    localparam logic [7:0]  MASK_NARROW    = 8'hAA;

    localparam logic [32:0] LEN_CAP = (33'd1 << LENGTH_BITS) - 33'd1;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_TRUNC = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    // one classified transaction between front and back
    typedef struct packed {
        kind_t       kind;
        logic        last;
        logic        wide;
        logic        first;
        logic [15:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[hw/rtl/xmsd_in_if.sv]
// input byte channel
`timescale 1ns / 1ps

interface xmsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] key_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output key_byte,
                    output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input key_byte,
                    input end_of_input, output ready);
endinterface

[hw/rtl/xmsd_out_if.sv]
// decoded result channel
`timescale 1ns / 1ps

interface xmsd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        last_char;
    logic [1:0]  result_kind;

    modport source (output valid, output char_code, output last_char,
                    output result_kind, input ready);
    modport sink   (input valid, input char_code, input last_char,
                    input result_kind, output ready);
endinterface

[hw/rtl/xor_masked_string_decoder_core.sv]
// top level of the masked length-prefixed string decoder
`timescale 1ns / 1ps

// Accepts one encoded byte per clock with its keystream byte and returns
// decoded characters, empty-string markers and truncation errors in input
// order. A parser stage registers the prefix, escaped length and byte-pair
// state each cycle and pushes classified transactions into a two-entry
// queue; a decode stage applies the rolling mask and holds the result in an
// output register. Sustained rate is one byte per cycle while the queue is
// not full; each result is written into the queue and then into the output
// register. Ready drops only when the queue is full.

module xor_masked_string_decoder_core
    import xmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    xmsd_in_if.sink    byte_ch,
    xmsd_out_if.source result_ch
);

    logic    push;
    logic    pop;
    cmd_t    push_data;
    cmd_t    pop_data;
    q_stat_t q_stat;
    logic    q_data_is_narrow_char;

    xmsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_stat  (q_stat),
        .push    (push),
        .cmd     (push_data)
    );

    xmsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    xmsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (pop_data),
        .pop       (pop),
        .result_ch (result_ch)
    );

    assign q_data_is_narrow_char = (pop_data.kind == KIND_CHAR) && !pop_data.wide;

    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("queue overflow");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("queue underflow");

    // empty and error results end a string and carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.result_kind != KIND_CHAR
        |-> result_ch.last_char && result_ch.char_code == 16'd0)
        else $error("marker result carries data");

    // a narrow character never sets the upper byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_data_is_narrow_char |=> result_ch.char_code[15:8] == 8'h00)
        else $error("narrow character has upper bits");

endmodule

[hw/rtl/xmsd_fifo.sv]
// two-entry queue between parser and decode stage
`timescale 1ns / 1ps

module xmsd_fifo
    import xmsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_data,
    input  logic    pop,
    output cmd_t    pop_data,
    output q_stat_t stat
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

[hw/rtl/xmsd_front.sv]
// byte parser: prefix, escaped length and payload byte pairing
`timescale 1ns / 1ps

module xmsd_front
    import xmsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    xmsd_in_if.sink byte_ch,
    input  q_stat_t q_stat,
    output logic    push,
    output cmd_t    cmd
);

    phase_t                 phase_reg, phase_next;
    logic                   wide_reg, wide_next;
    logic [1:0]             seen_reg, seen_next;
    logic [23:0]            len_acc_reg, len_acc_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [7:0]             low_reg, low_next;
    logic                   odd_reg, odd_next;
    logic                   first_reg, first_next;

    logic                   accepted;
    logic [7:0]             d;
    logic [7:0]             dk;
    logic [31:0]            full_len;
    logic [LENGTH_BITS-1:0] sat_len;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic [7:0]             narrow_cnt;

    assign byte_ch.ready = !q_stat.full;
    assign accepted      = byte_ch.valid && byte_ch.ready;
    assign d             = byte_ch.data_byte;
    assign dk            = byte_ch.data_byte ^ byte_ch.key_byte;
    assign full_len      = {d, len_acc_reg};
    assign sat_len       = ({1'b0, full_len} > LEN_CAP) ? LEN_CAP[LENGTH_BITS-1:0]
                                                        : full_len[LENGTH_BITS-1:0];
    assign narrow_cnt    = 8'd0 - d;
    assign remain_dec    = (remain_reg != '0) ? remain_reg - LENGTH_BITS'(1) : remain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            wide_reg    <= 1'b0;
            seen_reg    <= 2'd0;
            len_acc_reg <= '0;
            remain_reg  <= '0;
            low_reg     <= '0;
            odd_reg     <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            wide_reg    <= wide_next;
            seen_reg    <= seen_next;
            len_acc_reg <= len_acc_next;
            remain_reg  <= remain_next;
            low_reg     <= low_next;
            odd_reg     <= odd_next;
            first_reg   <= first_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        wide_next    = wide_reg;
        seen_next    = seen_reg;
        len_acc_next = len_acc_reg;
        remain_next  = remain_reg;
        low_next     = low_reg;
        odd_next     = odd_reg;
        first_next   = first_reg;
        push         = 1'b0;
        cmd          = '0;

        if (accepted)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (d == PREFIX_EMPTY)
                    begin
                        push      = 1'b1;
                        cmd.kind  = KIND_EMPTY;
                        cmd.last  = 1'b1;
                    end
                    else if (d == PREFIX_WIDE_X || d == PREFIX_NARR_X)
                    begin
                        wide_next    = (d == PREFIX_WIDE_X);
                        seen_next    = 2'd0;
                        len_acc_next = '0;
                        phase_next   = PH_LENGTH;
                    end
                    else
                    begin
                        wide_next   = !d[7];
                        remain_next = d[7] ? LENGTH_BITS'(narrow_cnt) : LENGTH_BITS'(d);
                        odd_next    = 1'b0;
                        low_next    = '0;
                        first_next  = 1'b1;
                        phase_next  = PH_PAYLOAD;
                    end
                end
                PH_LENGTH:
                begin
                    if (seen_reg == 2'd3)
                    begin
                        seen_next = 2'd0;
                        if (full_len == 32'd0 || full_len[31])
                        begin
                            remain_next = '0;
                            phase_next  = PH_PREFIX;
                            push        = 1'b1;
                            cmd.kind    = KIND_EMPTY;
                            cmd.last    = 1'b1;
                        end
                        else
                        begin
                            remain_next = sat_len;
                            odd_next    = 1'b0;
                            low_next    = '0;
                            first_next  = 1'b1;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        seen_next = seen_reg + 2'd1;
                        unique case (seen_reg)
                            2'd0:    len_acc_next[7:0]   = d;
                            2'd1:    len_acc_next[15:8]  = d;
                            default: len_acc_next[23:16] = d;
                        endcase
                    end
                end
                default:
                begin
                    if (wide_reg && !odd_reg)
                    begin
                        low_next = dk;
                        odd_next = 1'b1;
                    end
                    else
                    begin
                        odd_next    = 1'b0;
                        first_next  = 1'b0;
                        remain_next = remain_dec;
                        push        = 1'b1;
                        cmd.kind    = KIND_CHAR;
                        cmd.last    = (remain_dec == '0);
                        cmd.wide    = wide_reg;
                        cmd.first   = first_reg;
                        cmd.data    = wide_reg ? {dk, low_reg} : {8'h00, dk};
                        if (remain_dec == '0)
                        begin
                            phase_next = PH_PREFIX;
                        end
                    end
                end
            endcase

            if (byte_ch.end_of_input)
            begin
                // input cut inside a string replaces this byte's own result
                if (phase_next != PH_PREFIX)
                begin
                    push     = 1'b1;
                    cmd      = '0;
                    cmd.kind = KIND_TRUNC;
                    cmd.last = 1'b1;
                end
                phase_next   = PH_PREFIX;
                wide_next    = 1'b0;
                seen_next    = 2'd0;
                len_acc_next = '0;
                remain_next  = '0;
                low_next     = '0;
                odd_next     = 1'b0;
                first_next   = 1'b0;
            end
        end
    end

endmodule

[hw/rtl/xmsd_back.sv]
// decode stage: rolling mask and output register
`timescale 1ns / 1ps

module xmsd_back
    import xmsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  cmd_t        q_data,
    output logic        pop,
    xmsd_out_if.source  result_ch
);

    logic        out_valid_reg;
    logic [15:0] out_code_reg, out_code_next;
    logic        out_last_reg;
    kind_t       out_kind_reg;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] mask_cur;

    assign pop = !q_stat.empty && (!out_valid_reg || result_ch.ready);

    always_comb
    begin
        if (q_data.first)
        begin
            mask_cur = q_data.wide ? MASK_WIDE : {8'h00, MASK_NARROW};
        end
        else
        begin
            mask_cur = mask_reg;
        end

        mask_next     = mask_reg;
        out_code_next = '0;
        if (q_data.kind == KIND_CHAR)
        begin
            if (q_data.wide)
            begin
                out_code_next = q_data.data ^ mask_cur;
                mask_next     = mask_cur + 16'd1;
            end
            else
            begin
                out_code_next = {8'h00, q_data.data[7:0] ^ mask_cur[7:0]};
                mask_next     = {8'h00, mask_cur[7:0] + 8'd1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                mask_reg      <= mask_next;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_code_reg <= out_code_next;
            out_last_reg <= q_data.last;
            out_kind_reg <= q_data.kind;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.char_code   = out_code_reg;
    assign result_ch.last_char   = out_last_reg;
    assign result_ch.result_kind = out_kind_reg;

endmodule

[dv/xmsd_checker.sv]
// checker for the masked string decoder: predicts results from input bytes and compares them
`timescale 1ns / 1ps

module xmsd_checker
    import xmsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xmsd_in_if   byte_mon,
    xmsd_out_if  res_mon,
    output int   fail_count,
    output int   pending,
    output int   char_count,
    output int   empty_count,
    output int   trunc_count
);

    typedef struct packed {
        logic [15:0] code;
        logic        last;
        kind_t       kind;
    } decoded_t;

    decoded_t    decoded_q[$];

    phase_t      ph;
    logic        wide_mode;
    logic [1:0]  len_seen;
    logic [31:0] remaining;
    logic [15:0] mask;
    logic [7:0]  low_half;
    logic        odd;

    function automatic void clear_parse();
        ph        = PH_PREFIX;
        wide_mode = 1'b0;
        len_seen  = '0;
        remaining = '0;
        mask      = '0;
        low_half  = '0;
        odd       = 1'b0;
    endfunction

    function automatic void open_payload(input logic [31:0] count);
        mask      = wide_mode ? MASK_WIDE : {8'h00, MASK_NARROW};
        odd       = 1'b0;
        low_half  = '0;
        remaining = count;
        ph        = PH_PAYLOAD;
    endfunction

    function automatic bit decode_byte(input logic [7:0] d, input logic [7:0] k,
                                       input logic eoi, output decoded_t res);
        bit          got;
        bit          done;
        logic [31:0] acc;
        logic [15:0] code;
        got  = 0;
        done = 0;
        code = '0;
        res  = '0;
        case (ph)
            PH_PREFIX:
            begin
                if (d == PREFIX_EMPTY)
                begin
                    res = '{code: 16'h0000, last: 1'b1, kind: KIND_EMPTY};
                    got = 1;
                end
                else if (d == PREFIX_WIDE_X || d == PREFIX_NARR_X)
                begin
                    wide_mode = (d == PREFIX_WIDE_X);
                    len_seen  = '0;
                    remaining = '0;
                    ph        = PH_LENGTH;
                end
                else if (!d[7])
                begin
                    wide_mode = 1'b1;
                    open_payload(32'(d));
                end
                else
                begin
                    wide_mode = 1'b0;
                    open_payload(32'd256 - 32'(d));
                end
            end
            PH_LENGTH:
            begin
                acc       = remaining | (32'(d) << (8 * len_seen));
                remaining = acc;
                if (len_seen == 2'd3)
                begin
                    len_seen = '0;
                    if (acc == 32'd0 || acc[31])
                    begin
                        remaining = '0;
                        ph        = PH_PREFIX;
                        res = '{code: 16'h0000, last: 1'b1, kind: KIND_EMPTY};
                        got = 1;
                    end
                    else
                    begin
                        if ({1'b0, acc} > LEN_CAP)
                            acc = LEN_CAP[31:0];
                        open_payload(acc);
                    end
                end
                else
                    len_seen = len_seen + 2'd1;
            end
            default:
            begin
                if (wide_mode)
                begin
                    if (!odd)
                    begin
                        low_half = d ^ k;
                        odd      = 1'b1;
                    end
                    else
                    begin
                        code = {d ^ k, low_half} ^ mask;
                        mask = mask + 16'd1;
                        odd  = 1'b0;
                        done = 1;
                    end
                end
                else
                begin
                    code = {8'h00, d ^ k ^ mask[7:0]};
                    mask = {8'h00, mask[7:0] + 8'd1};
                    done = 1;
                end
                if (done)
                begin
                    if (remaining != 32'd0)
                        remaining = remaining - 32'd1;
                    if (remaining == 32'd0)
                        ph = PH_PREFIX;
                    res = '{code: code, last: (remaining == 32'd0), kind: KIND_CHAR};
                    got = 1;
                end
            end
        endcase
        if (eoi)
        begin
            if (ph != PH_PREFIX)
            begin
                res = '{code: 16'h0000, last: 1'b1, kind: KIND_TRUNC};
                got = 1;
            end
            clear_parse();
        end
        return got;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        decoded_t seen;
        if (!rst_n)
        begin
            clear_parse();
            decoded_q.delete();
            pending     <= 0;
            fail_count  <= 0;
            char_count  <= 0;
            empty_count <= 0;
            trunc_count <= 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
            begin
                if (decode_byte(byte_mon.data_byte, byte_mon.key_byte,
                                byte_mon.end_of_input, want))
                    decoded_q.insert(decoded_q.size(), want);
            end
            if (res_mon.valid && res_mon.ready)
            begin
                seen = '{code: res_mon.char_code, last: res_mon.last_char,
                         kind: kind_t'(res_mon.result_kind)};
                if (decoded_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    $display("%0t: unexpected result transaction: code %h last %b kind %0d",
                             $time, seen.code, seen.last, seen.kind);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (seen.code !== want.code || seen.last !== want.last
                        || seen.kind !== want.kind)
                    begin
                        fail_count <= fail_count + 1;
                        $display("%0t: mismatch: expected code %h last %b kind %0d, got code %h last %b kind %0d",
                                 $time, want.code, want.last, want.kind,
                                 seen.code, seen.last, seen.kind);
                    end
                    case (want.kind)
                        KIND_CHAR:  char_count  <= char_count + 1;
                        KIND_EMPTY: empty_count <= empty_count + 1;
                        default:    trunc_count <= trunc_count + 1;
                    endcase
                end
            end
            pending <= decoded_q.size();
        end
    end

endmodule

[dv/tb_top.sv]
// testbench top for the masked string decoder: stimulus, reset, clock and verdict
`timescale 1ns / 1ps

module tb_top;
    import xmsd_pkg::*;

    logic clk;
    logic rst_n;
    logic calm;
    int   items_sent;
    int   fail_count;
    int   pending;
    int   char_count;
    int   empty_count;
    int   trunc_count;
    bit   drained_mid;

    xmsd_in_if  byte_if();
    xmsd_out_if res_if();

    xor_masked_string_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .result_ch (res_if)
    );

    xmsd_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_mon    (byte_if),
        .res_mon     (res_if),
        .fail_count  (fail_count),
        .pending     (pending),
        .char_count  (char_count),
        .empty_count (empty_count),
        .trunc_count (trunc_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
    end

    task automatic send_byte(input logic [7:0] d, input logic [7:0] k, input logic eoi);
        while (!calm && $urandom_range(99) < 30)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid        <= 1'b1;
        byte_if.data_byte    <= d;
        byte_if.key_byte     <= k;
        byte_if.end_of_input <= eoi;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_string();
        logic [7:0]  seq[$];
        int unsigned pick;
        int unsigned n;
        int unsigned cut;
        int unsigned stop;
        logic [31:0] len;
        logic        wide;
        pick = $urandom_range(99);
        wide = $urandom_range(1);
        cut  = 0;
        if (pick < 8)
            seq.insert(seq.size(), PREFIX_EMPTY);
        else if (pick < 76)
        begin
            if ($urandom_range(19) == 0)
                n = $urandom_range(wide ? 126 : 127, 1);
            else
                n = $urandom_range(wide ? 6 : 8, 1);
            seq.insert(seq.size(), wide ? 8'(n) : 8'(256 - n));
            repeat (wide ? 2 * n : n) seq.insert(seq.size(), 8'($urandom));
        end
        else if (pick < 88)
        begin
            case ($urandom_range(3))
                0:       len = 32'd0;
                1:       len = {1'b1, 31'($urandom)};
                default: len = $urandom_range(5, 1);
            endcase
            seq.insert(seq.size(), wide ? PREFIX_WIDE_X : PREFIX_NARR_X);
            for (int i = 0; i < 4; i++)
                seq.insert(seq.size(), len[8 * i +: 8]);
            if (len != 32'd0 && !len[31])
                repeat (wide ? 2 * len : len) seq.insert(seq.size(), 8'($urandom));
        end
        else if (pick < 94)
        begin
            // strings cut short by end of input
            case ($urandom_range(2))
                0:
                begin
                    n = $urandom_range(4, 1);
                    seq.insert(seq.size(), wide ? 8'(n) : 8'(256 - n));
                    repeat (wide ? 2 * n : n) seq.insert(seq.size(), 8'($urandom));
                    cut = $urandom_range(seq.size() - 1, 1);
                end
                1:
                begin
                    len = $urandom_range(4, 1);
                    seq.insert(seq.size(), wide ? PREFIX_WIDE_X : PREFIX_NARR_X);
                    for (int i = 0; i < 4; i++)
                        seq.insert(seq.size(), len[8 * i +: 8]);
                    repeat (wide ? 2 * len : len) seq.insert(seq.size(), 8'($urandom));
                    cut = $urandom_range(seq.size() - 1, 1);
                end
                default:
                begin
                    len = {1'b0, 31'($urandom)} | 32'h0000_0100;
                    seq.insert(seq.size(), wide ? PREFIX_WIDE_X : PREFIX_NARR_X);
                    for (int i = 0; i < 4; i++)
                        seq.insert(seq.size(), len[8 * i +: 8]);
                    repeat ($urandom_range(6)) seq.insert(seq.size(), 8'($urandom));
                    cut = seq.size();
                end
            endcase
        end
        else
        begin
            // noise bytes closed by end of input
            n = $urandom_range(6, 1);
            repeat (n) seq.insert(seq.size(), 8'($urandom));
            cut = n;
        end
        if (cut == 0 && $urandom_range(19) == 0)
            cut = seq.size();
        stop = (cut != 0) ? cut : seq.size();
        for (int i = 0; i < stop; i++)
            send_byte(seq[i], 8'($urandom), (cut != 0) && (i == cut - 1));
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        calm                 = 1'b0;
        items_sent           = 0;
        drained_mid          = 0;
        byte_if.valid        = 1'b0;
        byte_if.data_byte    = '0;
        byte_if.key_byte     = '0;
        byte_if.end_of_input = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string
        send_byte(PREFIX_EMPTY, 8'h00, 1'b0);
        // one wide char, input ends right after it
        send_byte(8'h01, 8'hFF, 1'b0);
        send_byte(8'h00, 8'hFF, 1'b0);
        send_byte(8'hFF, 8'h00, 1'b1);
        // one narrow char
        send_byte(8'hFF, 8'h00, 1'b0);
        send_byte(8'hFF, 8'hFF, 1'b0);
        // escaped length zero
        send_byte(PREFIX_WIDE_X, 8'h00, 1'b0);
        repeat (4) send_byte(8'h00, 8'hFF, 1'b0);
        // escaped length negative
        send_byte(PREFIX_NARR_X, 8'hFF, 1'b0);
        repeat (4) send_byte(8'hFF, 8'h00, 1'b0);
        // escaped narrow length one
        send_byte(PREFIX_NARR_X, 8'h00, 1'b0);
        send_byte(8'h01, 8'h00, 1'b0);
        repeat (3) send_byte(8'h00, 8'h00, 1'b0);
        send_byte(8'h55, 8'hAA, 1'b0);
        // end inside payload
        send_byte(8'hFE, 8'h00, 1'b0);
        send_byte(8'h12, 8'h34, 1'b1);
        // end on a prefix that needs more bytes
        send_byte(8'h05, 8'h00, 1'b1);
        // end inside the escaped length
        send_byte(PREFIX_WIDE_X, 8'h00, 1'b0);
        send_byte(8'h01, 8'h00, 1'b0);
        send_byte(8'h00, 8'h00, 1'b1);
        // empty string as the last byte
        send_byte(PREFIX_EMPTY, 8'hFF, 1'b1);
        wait_drained();

        while (items_sent < 1100)
        begin
            calm = (items_sent >= 450 && items_sent < 700);
            if (!drained_mid && items_sent >= 800)
            begin
                wait_drained();
                drained_mid = 1;
            end
            send_random_string();
        end
        calm = 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d input bytes; checked %0d chars, %0d empty strings, %0d truncations",
                 items_sent, char_count, empty_count, trunc_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS xor_masked_string_decoder_core");
        else
            $display("FAIL xor_masked_string_decoder_core");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL xor_masked_string_decoder_core");
        $finish;
    end

endmodule
